[rtl/mce_pkg.sv]
// Package with the shared types, codes and constants of the MIDI channel message encoder.
`timescale 1ns / 1ps

package mce_pkg;

  localparam int IDX_W = 4;

  localparam logic [3:0] ACT_NOTE_OFF    = 4'd0;
  localparam logic [3:0] ACT_NOTE_ON     = 4'd1;
  localparam logic [3:0] ACT_POLY_PRESS  = 4'd2;
  localparam logic [3:0] ACT_CTRL        = 4'd3;
  localparam logic [3:0] ACT_PROGRAM     = 4'd4;
  localparam logic [3:0] ACT_CHAN_PRESS  = 4'd5;
  localparam logic [3:0] ACT_BEND        = 4'd6;
  localparam logic [3:0] ACT_NRPN_7      = 4'd7;
  localparam logic [3:0] ACT_NRPN_14     = 4'd8;
  localparam logic [3:0] ACT_RPN_7       = 4'd9;
  localparam logic [3:0] ACT_RPN_14      = 4'd10;

  localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
  localparam logic [3:0] KIND_POLY_PRESS = 4'hA;
  localparam logic [3:0] KIND_CTRL       = 4'hB;
  localparam logic [3:0] KIND_PROGRAM    = 4'hC;
  localparam logic [3:0] KIND_CHAN_PRESS = 4'hD;
  localparam logic [3:0] KIND_BEND       = 4'hE;

  localparam logic [6:0] CC_NRPN_MSB = 7'd99;
  localparam logic [6:0] CC_NRPN_LSB = 7'd98;
  localparam logic [6:0] CC_RPN_MSB  = 7'd101;
  localparam logic [6:0] CC_RPN_LSB  = 7'd100;
  localparam logic [6:0] CC_DATA_MSB = 7'd6;
  localparam logic [6:0] CC_DATA_LSB = 7'd38;

  typedef struct packed {
    logic [3:0]         action;
    logic [3:0]         channel;
    logic [6:0]         key;
    logic [13:0]        value;
    logic signed [13:0] bend;
    logic [13:0]        parameter_req;
  } mce_req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } mce_byte_t;

  // Number of bytes in the message for one action; undefined codes send nothing.
  function automatic logic [IDX_W-1:0] msg_len(input logic [3:0] action);
    logic [IDX_W-1:0] len;
    unique case (action) inside
      ACT_NOTE_OFF, ACT_NOTE_ON, ACT_POLY_PRESS, ACT_CTRL, ACT_BEND: len = IDX_W'(3);
      ACT_PROGRAM, ACT_CHAN_PRESS:                                 len = IDX_W'(2);
      ACT_NRPN_7, ACT_RPN_7:                                       len = IDX_W'(9);
      ACT_NRPN_14, ACT_RPN_14:                                     len = IDX_W'(12);
      default:                                                     len = '0;
    endcase
    return len;
  endfunction

endpackage

[rtl/midi_channel_message_encoder.sv]
// Top level of the MIDI channel message encoder: request register, byte counter, output register.
//
// One request transfer on the input channel (in_valid, in_stall) carries the message kind,
// channel, key, value, bend and parameter number. The output channel (out_valid, out_stall)
// then carries the message bytes in transmit order, one byte per transfer, with last set
// on the final byte. Messages are 2, 3, 9 or 12 bytes long; undefined action codes are
// taken and send no bytes.
// A request transfer first fills the request register; its first byte is then loaded into the output register.
// Bytes leave at one per cycle while the receiver does not stall. The next request is taken in
// the cycle its predecessor's final byte is loaded, so back-to-back requests stream with no gap.
// A stall holds the output register and the byte counter; while the request register
// holds a request, in_stall is high until the final byte of the held request is loaded.
// Synchronous reset empties the request and output registers; no byte is in flight after it.
`timescale 1ns / 1ps

module midi_channel_message_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         action,
  input  logic [3:0]         channel,
  input  logic [6:0]         key,
  input  logic [13:0]        value,
  input  logic signed [13:0] bend,
  input  logic [13:0]        parameter_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         tx_byte,
  output logic               last
);
  import mce_pkg::*;

  mce_req_t         req;
  logic             req_valid;
  logic [IDX_W-1:0] idx;
  mce_byte_t        cur;
  logic             load;
  logic             accept;

  mce_byte_gen u_byte_gen (
    .req    (req),
    .idx    (idx),
    .result (cur)
  );

  assign load     = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !(load && cur.last);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (cur.last) begin
          req_valid <= 1'b0;
          idx       <= '0;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      // A request with no bytes is taken and dropped.
      if (accept) begin
        req_valid <= (msg_len(action) != '0);
        idx       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.action        <= action;
      req.channel       <= channel;
      req.key           <= key;
      req.value         <= value;
      req.bend          <= bend;
      req.parameter_req <= parameter_req;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte <= cur.tx_byte;
      last    <= cur.last;
    end
  end

endmodule

[rtl/mce_byte_gen.sv]
// Byte selector: gives one byte of a held message request and flags the final byte.
`timescale 1ns / 1ps

module mce_byte_gen (
  input  mce_pkg::mce_req_t          req,
  input  logic [mce_pkg::IDX_W-1:0]  idx,
  output mce_pkg::mce_byte_t         result
);
  import mce_pkg::*;

  logic [3:0]  kind;
  logic [13:0] shifted;
  logic [1:0]  cc_group;
  logic [1:0]  cc_pos;
  logic [6:0]  cc_ctrl;
  logic [6:0]  cc_data;
  logic        rpn;
  logic        wide;
  logic [IDX_W-1:0] len;

  // Adding the bend centre to a 14-bit two's complement value flips its top bit.
  assign shifted = {~req.bend[13], req.bend[12:0]};
  assign rpn     = (req.action == ACT_RPN_7) || (req.action == ACT_RPN_14);
  assign wide    = (req.action == ACT_NRPN_14) || (req.action == ACT_RPN_14);
  assign len     = msg_len(req.action);

  always_comb begin
    unique case (req.action) inside
      ACT_NOTE_OFF:   kind = KIND_NOTE_OFF;
      ACT_NOTE_ON:    kind = KIND_NOTE_ON;
      ACT_POLY_PRESS: kind = KIND_POLY_PRESS;
      ACT_PROGRAM:    kind = KIND_PROGRAM;
      ACT_CHAN_PRESS: kind = KIND_CHAN_PRESS;
      ACT_BEND:       kind = KIND_BEND;
      default:        kind = KIND_CTRL;
    endcase
  end

  // Parameter sequences are a run of control changes of three bytes each.
  always_comb begin
    case (idx)
      4'd0, 4'd1, 4'd2:   cc_group = 2'd0;
      4'd3, 4'd4, 4'd5:   cc_group = 2'd1;
      4'd6, 4'd7, 4'd8:   cc_group = 2'd2;
      default:            cc_group = 2'd3;
    endcase
    case (idx)
      4'd0, 4'd3, 4'd6, 4'd9:  cc_pos = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10: cc_pos = 2'd1;
      default:                 cc_pos = 2'd2;
    endcase
  end

  always_comb begin
    case (cc_group)
      2'd0: begin
        cc_ctrl = rpn ? CC_RPN_MSB : CC_NRPN_MSB;
        cc_data = req.parameter_req[13:7];
      end
      2'd1: begin
        cc_ctrl = rpn ? CC_RPN_LSB : CC_NRPN_LSB;
        cc_data = req.parameter_req[6:0];
      end
      2'd2: begin
        cc_ctrl = CC_DATA_MSB;
        cc_data = wide ? req.value[13:7] : req.value[6:0];
      end
      default: begin
        cc_ctrl = CC_DATA_LSB;
        cc_data = req.value[6:0];
      end
    endcase
  end

  always_comb begin
    unique case (req.action) inside
      ACT_NOTE_OFF, ACT_NOTE_ON, ACT_POLY_PRESS, ACT_CTRL: begin
        case (idx)
          4'd0:    result.tx_byte = {kind, req.channel};
          4'd1:    result.tx_byte = {1'b0, req.key};
          default: result.tx_byte = {1'b0, req.value[6:0]};
        endcase
      end
      ACT_PROGRAM: begin
        result.tx_byte = (idx == '0) ? {kind, req.channel} : {1'b0, req.key};
      end
      ACT_CHAN_PRESS: begin
        result.tx_byte = (idx == '0) ? {kind, req.channel} : {1'b0, req.value[6:0]};
      end
      ACT_BEND: begin
        case (idx)
          4'd0:    result.tx_byte = {kind, req.channel};
          4'd1:    result.tx_byte = {1'b0, shifted[6:0]};
          default: result.tx_byte = {1'b0, shifted[13:7]};
        endcase
      end
      default: begin
        case (cc_pos)
          2'd0:    result.tx_byte = {KIND_CTRL, req.channel};
          2'd1:    result.tx_byte = {1'b0, cc_ctrl};
          default: result.tx_byte = {1'b0, cc_data};
        endcase
      end
    endcase
    result.last = (idx == len - IDX_W'(1));
  end

endmodule
